FILE: design/point_in_polygon_crossing_defines.svh
// Assertion macros shared by the point-in-polygon block.
`ifndef POINT_IN_POLYGON_CROSSING_DEFINES_SVH
`define POINT_IN_POLYGON_CROSSING_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PIPC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pipc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pipc assertion failed");

`else

`define PIPC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PIPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: design/pipc_pkg.sv
package pipc_pkg;

  // Default coordinate width and queue depth.
  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Vertex count saturates here; three or more vertices make a real polygon.
  localparam logic [1:0] SEEN_SAT = 2'd3;

  // Coordinate words carried per queue entry.
  localparam int ENTRY_COORDS = 8;

  // Classification of one vertex transaction, handed from front to back.
  typedef struct packed {
    logic edge_a;      // edge from the previous vertex is tested
    logic edge_b;      // closing edge back to the first vertex is tested
    logic short_poly;  // fewer than three vertices so far
  } item_flags_t;

endpackage

FILE: design/pipc_queue.sv
module pipc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pipc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/pipc_front.sv
module pipc_front #(
  parameter int COORD_BITS = pipc_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]                  vertex_x_i,
  input  logic signed [COORD_BITS-1:0]                  vertex_y_i,
  input  logic signed [COORD_BITS-1:0]                  target_x_i,
  input  logic signed [COORD_BITS-1:0]                  target_y_i,
  input  logic                                          last_vertex_i,
  output logic                                          push_valid_o,
  input  logic                                          push_ready_i,
  output pipc_pkg::item_flags_t                         push_flags_o,
  output logic [pipc_pkg::ENTRY_COORDS*COORD_BITS-1:0]  push_data_o
);

  logic [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [COORD_BITS-1:0] first_x_eff, first_y_eff;
  logic [1:0]            seen_q;
  logic                  accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;

  // The first vertex of a polygon is its own closing point.
  assign first_x_eff = (seen_q == '0) ? vertex_x_i : first_x_q;
  assign first_y_eff = (seen_q == '0) ? vertex_y_i : first_y_q;

  // Classify the transaction and gather every coordinate the edge tests need.
  always_comb begin
    push_flags_o.edge_a     = (seen_q != '0);
    push_flags_o.edge_b     = last_vertex_i;
    push_flags_o.short_poly = (seen_q < 2'd2);
    push_data_o = {prev_x_q, prev_y_q, vertex_x_i, vertex_y_i,
                   first_x_eff, first_y_eff, target_x_i, target_y_i};
  end

  // Polygon tracking state; a last vertex returns it to the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      seen_q    <= '0;
    end else if (accept) begin
      if (last_vertex_i) begin
        first_x_q <= '0;
        first_y_q <= '0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        seen_q    <= '0;
      end else begin
        first_x_q <= first_x_eff;
        first_y_q <= first_y_eff;
        prev_x_q  <= vertex_x_i;
        prev_y_q  <= vertex_y_i;
        if (seen_q != pipc_pkg::SEEN_SAT) begin
          seen_q <= seen_q + 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/pipc_edge.sv
module pipc_edge #(
  parameter int COORD_BITS = pipc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         active_i,
  input  logic signed [COORD_BITS-1:0] xo_i,
  input  logic signed [COORD_BITS-1:0] yo_i,
  input  logic signed [COORD_BITS-1:0] xn_i,
  input  logic signed [COORD_BITS-1:0] yn_i,
  input  logic signed [COORD_BITS-1:0] xt_i,
  input  logic signed [COORD_BITS-1:0] yt_i,
  output logic                         cross_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic signed [DW-1:0]         ya_d, xb_d, yc_d, xd_d;
  logic signed [DW-1:0]         ya_q, xb_q, yc_q, xd_q;
  logic signed [PW-1:0]         lhs_d, rhs_d, lhs_q, rhs_q;
  logic                         span_miss, ok1_d, ok1_q, ok2_q;

  // Order the endpoints by x; a tie puts the new vertex first.
  always_comb begin
    if (xn_i > xo_i) begin
      x1 = xo_i;
      y1 = yo_i;
      x2 = xn_i;
      y2 = yn_i;
    end else begin
      x1 = xn_i;
      y1 = yn_i;
      x2 = xo_i;
      y2 = yo_i;
    end
    span_miss = ((xn_i < xt_i) != (xt_i <= xo_i));
    ok1_d     = active_i & ~span_miss;
    ya_d = DW'(yt_i) - DW'(y1);
    xb_d = DW'(x2)   - DW'(x1);
    yc_d = DW'(y2)   - DW'(y1);
    xd_d = DW'(xt_i) - DW'(x1);
  end

  assign lhs_d = PW'(ya_q) * PW'(xb_q);
  assign rhs_d = PW'(yc_q) * PW'(xd_q);

  // Difference stage, then product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok1_q <= 1'b0;
      ok2_q <= 1'b0;
    end else if (en_i) begin
      ok1_q <= ok1_d;
      ok2_q <= ok1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ya_q  <= ya_d;
      xb_q  <= xb_d;
      yc_q  <= yc_d;
      xd_q  <= xd_d;
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  // The target lies below the edge when the left product is the smaller one.
  assign cross_o = ok2_q & (lhs_q < rhs_q);

endmodule

FILE: design/pipc_back.sv
module pipc_back #(
  parameter int COORD_BITS = pipc_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          pop_valid_i,
  output logic                                          pop_ready_o,
  input  pipc_pkg::item_flags_t                         pop_flags_i,
  input  logic [pipc_pkg::ENTRY_COORDS*COORD_BITS-1:0]  pop_data_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic                                          inside_res_o
);

  localparam int W = COORD_BITS;

  logic signed [W-1:0] prev_x, prev_y, vert_x, vert_y;
  logic signed [W-1:0] first_x, first_y, targ_x, targ_y;
  logic                en, cross_a, cross_b, parity_next;
  logic                vld_s1_q, vld_s2_q;
  logic                last_s1_q, last_s2_q, short_s1_q, short_s2_q;
  logic                parity_q, out_valid_q, out_res_q;

  // Unpack the queue entry.
  assign prev_x  = pop_data_i[8*W-1 -: W];
  assign prev_y  = pop_data_i[7*W-1 -: W];
  assign vert_x  = pop_data_i[6*W-1 -: W];
  assign vert_y  = pop_data_i[5*W-1 -: W];
  assign first_x = pop_data_i[4*W-1 -: W];
  assign first_y = pop_data_i[3*W-1 -: W];
  assign targ_x  = pop_data_i[2*W-1 -: W];
  assign targ_y  = pop_data_i[W-1:0];

  // The whole pipeline advances unless a result waits at the output.
  assign en          = ~out_valid_q | out_ready_i;
  assign pop_ready_o = en;

  // Edge from the previous vertex to this one.
  pipc_edge #(.COORD_BITS(COORD_BITS)) u_edge_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .active_i (pop_valid_i & pop_flags_i.edge_a),
    .xo_i     (prev_x),
    .yo_i     (prev_y),
    .xn_i     (vert_x),
    .yn_i     (vert_y),
    .xt_i     (targ_x),
    .yt_i     (targ_y),
    .cross_o  (cross_a)
  );

  // Closing edge from this vertex back to the first one.
  pipc_edge #(.COORD_BITS(COORD_BITS)) u_edge_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .active_i (pop_valid_i & pop_flags_i.edge_b),
    .xo_i     (vert_x),
    .yo_i     (vert_y),
    .xn_i     (first_x),
    .yn_i     (first_y),
    .xt_i     (targ_x),
    .yt_i     (targ_y),
    .cross_o  (cross_b)
  );

  assign parity_next = parity_q ^ cross_a ^ cross_b;

  // Transaction tags travel alongside the edge units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s1_q   <= 1'b0;
      vld_s2_q   <= 1'b0;
      last_s1_q  <= 1'b0;
      last_s2_q  <= 1'b0;
      short_s1_q <= 1'b0;
      short_s2_q <= 1'b0;
    end else if (en) begin
      vld_s1_q   <= pop_valid_i;
      vld_s2_q   <= vld_s1_q;
      last_s1_q  <= pop_flags_i.edge_b;
      last_s2_q  <= last_s1_q;
      short_s1_q <= pop_flags_i.short_poly;
      short_s2_q <= short_s1_q;
    end
  end

  // Parity accumulation and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= 1'b0;
    end else begin
      if (en && vld_s2_q) begin
        if (last_s2_q) begin
          parity_q    <= 1'b0;
          out_valid_q <= 1'b1;
          out_res_q   <= ~short_s2_q & parity_next;
        end else begin
          parity_q <= parity_next;
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

endmodule

FILE: design/point_in_polygon_crossing.sv
// Even-odd ray crossing test over a streamed polygon: one vertex is taken per
// transaction together with the target point, and the transaction flagged as
// the last vertex yields one result (1 inside, 0 outside or fewer than three
// vertices). The block takes one vertex per clock cycle while the queue has room;
// an accepted vertex passes through the queue, the coordinate difference stage and
// the registered multiplier stage of the edge units that test the incoming
// edge and the closing edge side by side, and then through the output register.
// A short queue lets input keep flowing while the output is stalled.
`include "point_in_polygon_crossing_defines.svh"

module point_in_polygon_crossing #(
  parameter int COORD_BITS  = pipc_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = pipc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic signed [COORD_BITS-1:0] target_x_i,
  input  logic signed [COORD_BITS-1:0] target_y_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o
);

  localparam int DATA_W  = pipc_pkg::ENTRY_COORDS * COORD_BITS;
  localparam int FLAGS_W = $bits(pipc_pkg::item_flags_t);
  localparam int ENTRY_W = FLAGS_W + DATA_W;

  pipc_pkg::item_flags_t push_flags, pop_flags;
  logic [DATA_W-1:0]     push_data, pop_data;
  logic [ENTRY_W-1:0]    pop_entry;
  logic                  push_valid, push_ready, pop_valid, pop_ready;

  // Front: tracks the polygon and classifies each vertex.
  pipc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .last_vertex_i (last_vertex_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_flags_o  (push_flags),
    .push_data_o   (push_data)
  );

  // Queue between the front and the edge pipeline.
  pipc_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_flags, push_data}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_entry)
  );

  assign pop_flags = pipc_pkg::item_flags_t'(pop_entry[ENTRY_W-1 -: FLAGS_W]);
  assign pop_data  = pop_entry[DATA_W-1:0];

  // Back: edge tests, parity and result.
  pipc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_flags_i  (pop_flags),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o)
  );

  // An accepted vertex is waiting in the queue on the next cycle.
  `PIPC_ASSERT_NEXT(a_accept_fills_queue, clk_i, rst_ni, in_valid_i && in_ready_o, pop_valid)
  // An empty queue always has room.
  `PIPC_ASSERT_NOW(a_empty_has_room, clk_i, rst_ni, !pop_valid, in_ready_o)
  // A stalled result freezes the edge pipeline.
  `PIPC_ASSERT_NOW(a_stall_holds_pipe, clk_i, rst_ni, out_valid_o && !out_ready_i, !pop_ready)

endmodule
